@@ hw/rtl/tmo_pkg.sv @@
// Tone map operator package: shared types, codes, widths and the
// elaboration-time builders of the log2 and exp2 interpolation tables.
// No dependencies.
package tmo_pkg;

  localparam int OUT_FRAC_BITS_DEF  = 16;
  localparam int LOG_TABLE_BITS_DEF = 8;

  localparam int LUM_W      = 32;  // Q16.16 luminance and config words
  localparam int GAM_W      = 16;  // Q4.12 exponent
  localparam int GAM_FRAC   = 12;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int LQ         = 24;  // log2 fraction bits
  localparam int LG_W       = 30;  // log2 value, integer part up to 32
  localparam int EXP_Q      = 30;  // exp2 table fraction bits

  localparam logic [LUM_W-1:0] LUM_ONE = LUM_W'(1) << 16;
  localparam logic [LG_W-1:0]  LOG_OFF = LG_W'(16) << LQ;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLAMP,
    MODE_EQ,
    MODE_EQ_CLAMP,
    MODE_GAMMA,
    MODE_GAMMA_CLAMP,
    MODE_LOG_MAX,
    MODE_LOG_ALPHA
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_RANGE,
    ST_CFG
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_MAX_LUM,
    REG_CLAMP,
    REG_GAMMA,
    REG_ALPHA
  } reg_idx_t;

  // Per-sample control that travels alongside the datapath
  typedef struct packed {
    status_t            status;
    logic [MODE_W-1:0]  mode;
    logic               force_one;
    logic               force_zero;
    logic [LUM_W-1:0]   lum;
  } ctl_t;

  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    longint unsigned vv;
    r  = 0;
    vv = v;
    b  = 64'd1 << 62;
    while (b > vv) b = b >> 2;
    while (b != 0) begin
      if (vv >= r + b) begin
        vv = vv - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2(1 + i/2^t) in Q24, by repeated squaring
  function automatic logic [LQ:0] log_entry(int t, int i);
    longint unsigned x;
    longint unsigned res;
    if (i == (1 << t)) return (LQ+1)'(1) << LQ;
    x   = (64'd1 << 30) + (longint'(i) << (30 - t));
    res = 0;
    for (int b = 1; b <= LQ; b++) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        res = res | (64'd1 << (LQ - b));
        x   = x >> 1;
      end
    end
    return (LQ+1)'(res);
  endfunction

  // 2^(-i/2^t) in Q30, product of rounded root constants
  function automatic logic [EXP_Q:0] exp_entry(int t, int i);
    longint unsigned root [13];
    longint unsigned p;
    if (i == (1 << t)) return (EXP_Q+1)'(1) << 29;
    for (int k = 0; k < 13; k++) root[k] = 0;
    root[1] = isqrt64(64'd1 << 59);
    for (int k = 2; k <= t; k++) root[k] = isqrt64(root[k-1] << 30);
    p = 64'd1 << 30;
    for (int k = 1; k <= t; k++) begin
      if (((i >> (t - k)) & 1) != 0) p = (p * root[k] + (64'd1 << 29)) >> 30;
    end
    return (EXP_Q+1)'(p);
  endfunction

endpackage

@@ hw/rtl/tmo_if.sv @@
// Tone map operator channel interfaces: sample input, result output and
// configuration write. Depends on tmo_pkg.
interface tmo_in_if import tmo_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LUM_W-1:0] luminance;
  modport source (output valid, output luminance, input ready);
  modport sink   (input valid, input luminance, output ready);
endinterface

interface tmo_out_if import tmo_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [OUT_FRAC_BITS:0] mapped_value;
  logic [1:0]             status;
  modport source (output valid, output mapped_value, output status, input ready);
  modport sink   (input valid, input mapped_value, input status, output ready);
endinterface

interface tmo_cfg_if import tmo_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/tmo_div.sv @@
// Tone map operator pipelined restoring divider, one quotient bit a stage.
// Caller guarantees num < den * 2^QW. Depends on tmo_pkg.
module tmo_div import tmo_pkg::*; #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  ctl_t          in_ctl,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          out_vld,
  output ctl_t          out_ctl,
  output logic [QW-1:0] quo
);

  localparam int W = DW + QW;

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];
  ctl_t          ctl_r [QW];
  logic          vld_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] rem_s;
    logic [DW-1:0] den_s;
    logic [QW-1:0] quo_s;
    ctl_t          ctl_s;
    logic          vld_s;
    logic [W-1:0]  dsh;
    logic          take;
    logic [NW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign rem_s = num;
      assign den_s = den;
      assign quo_s = '0;
      assign ctl_s = in_ctl;
      assign vld_s = in_vld;
    end else begin : g_next
      assign rem_s = rem_r[k-1];
      assign den_s = den_r[k-1];
      assign quo_s = quo_r[k-1];
      assign ctl_s = ctl_r[k-1];
      assign vld_s = vld_r[k-1];
    end

    assign dsh  = W'(den_s) << (QW - 1 - k);
    assign take = (W'(rem_s) >= dsh);

    always_comb begin
      rem_nxt = take ? (rem_s - dsh[NW-1:0]) : rem_s;
      quo_nxt = quo_s;
      quo_nxt[QW-1-k] = take;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_s;
        quo_r[k] <= quo_nxt;
        ctl_r[k] <= ctl_s;
      end
    end
  end

  assign out_vld = vld_r[QW-1];
  assign out_ctl = ctl_r[QW-1];
  assign quo     = quo_r[QW-1];

endmodule

@@ hw/rtl/tmo_log2.sv @@
// Tone map operator dual-lane log2 unit, four stages: leading one,
// normalise and table lookup, interpolation multiply, sum. Depends on tmo_pkg.
module tmo_log2 import tmo_pkg::*; #(
  parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  ctl_t            in_ctl,
  input  logic [LUM_W:0]  xa,
  input  logic [LUM_W:0]  xb,
  output logic            out_vld,
  output ctl_t            out_ctl,
  output logic [LG_W-1:0] lga,
  output logic [LG_W-1:0] lgb
);

  localparam int T   = LOG_TABLE_BITS;
  localparam int TN  = 1 << T;
  localparam int LAT = 4;
  localparam int EW  = $clog2(LUM_W + 1);
  localparam int RW  = LUM_W - 1 - T;

  logic [LQ:0] ltab [TN+1];

  for (genvar i = 0; i <= TN; i++) begin : g_tab
    localparam logic [LQ:0] ENT = log_entry(T, i);
    assign ltab[i] = ENT;
  end

  logic vld_r [LAT];
  ctl_t ctl_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= in_ctl;
      for (int k = 1; k < LAT; k++) ctl_r[k] <= ctl_r[k-1];
    end
  end

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    logic [LUM_W:0]          x_s;
    logic [EW-1:0]           e_nxt;
    logic [LUM_W:0]          x1_r;
    logic [EW-1:0]           e1_r;
    logic                    z1_r;
    logic [2*LUM_W-1:0]      mfull;
    logic [LUM_W-2:0]        f;
    logic [T-1:0]            idx;
    logic [LQ:0]             lo;
    logic [LQ:0]             hi;
    logic [EW-1:0]           e2_r;
    logic [LQ:0]             lo2_r;
    logic [LQ:0]             df2_r;
    logic [RW-1:0]           rm2_r;
    logic                    z2_r;
    logic [LQ+1+RW-1:0]      pr;
    logic [EW-1:0]           e3_r;
    logic [LQ:0]             lo3_r;
    logic [LQ:0]             fr3_r;
    logic                    z3_r;
    logic [LG_W-1:0]         lg_r;

    assign x_s = (ln == 0) ? xa : xb;

    // leading one position
    always_comb begin
      e_nxt = '0;
      for (int b = 0; b <= LUM_W; b++) begin
        if (x_s[b]) e_nxt = EW'(b);
      end
    end

    // mantissa with its leading one at bit LUM_W-1
    assign mfull = {x1_r, {(LUM_W-1){1'b0}}} >> e1_r;
    assign f     = mfull[LUM_W-2:0];
    assign idx   = f[LUM_W-2 -: T];
    assign lo    = ltab[(T+1)'(idx)];
    assign hi    = ltab[(T+1)'(idx) + (T+1)'(1)];
    assign pr    = df2_r * rm2_r;

    always_ff @(posedge clk) begin
      if (en) begin
        x1_r  <= x_s;
        e1_r  <= e_nxt;
        z1_r  <= (x_s == '0);
        e2_r  <= e1_r;
        lo2_r <= lo;
        df2_r <= hi - lo;
        rm2_r <= f[RW-1:0];
        z2_r  <= z1_r;
        e3_r  <= e2_r;
        lo3_r <= lo2_r;
        fr3_r <= (LQ+1)'(pr >> RW);
        z3_r  <= z2_r;
        lg_r  <= z3_r ? '0
               : (LG_W'(e3_r) << LQ) + LG_W'(lo3_r) + LG_W'(fr3_r);
      end
    end

    if (ln == 0) begin : g_a
      assign lga = lg_r;
    end else begin : g_b
      assign lgb = lg_r;
    end
  end

  assign out_vld = vld_r[LAT-1];
  assign out_ctl = ctl_r[LAT-1];

endmodule

@@ hw/rtl/tmo_exp2.sv @@
// Tone map operator power unit, four stages: exponent scaling, exp2 table
// lookup, interpolation multiply, subtract and shift. Depends on tmo_pkg.
module tmo_exp2 import tmo_pkg::*; #(
  parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF,
  parameter int OUT_FRAC_BITS  = OUT_FRAC_BITS_DEF,
  parameter int AW             = 80
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  ctl_t                   in_ctl,
  input  logic [LG_W-1:0]        d,
  input  logic [GAM_W-1:0]       g,
  input  logic [AW-1:0]          aux_in,
  output logic                   out_vld,
  output ctl_t                   out_ctl,
  output logic [OUT_FRAC_BITS:0] res,
  output logic [AW-1:0]          aux_out
);

  localparam int T   = LOG_TABLE_BITS;
  localparam int TN  = 1 << T;
  localparam int F   = OUT_FRAC_BITS;
  localparam int LAT = 4;
  localparam int PW  = LG_W + GAM_W - GAM_FRAC;
  localparam int NBW = PW - LQ;
  localparam int SW  = NBW + 1;
  localparam int RW  = LQ - T;

  logic [EXP_Q:0] etab [TN+1];

  for (genvar i = 0; i <= TN; i++) begin : g_tab
    localparam logic [EXP_Q:0] ENT = exp_entry(T, i);
    assign etab[i] = ENT;
  end

  logic vld_r [LAT];
  ctl_t ctl_r [LAT];
  logic [AW-1:0] aux_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  logic [LG_W+GAM_W-1:0] prod;
  logic [PW-1:0]         p1_r;
  logic [T-1:0]          idx;
  logic [EXP_Q:0]        lo;
  logic [NBW-1:0]        n2_r;
  logic [EXP_Q:0]        lo2_r;
  logic [EXP_Q:0]        df2_r;
  logic [RW-1:0]         rm2_r;
  logic [EXP_Q+1+RW-1:0] pr;
  logic [NBW-1:0]        n3_r;
  logic [EXP_Q:0]        lo3_r;
  logic [EXP_Q:0]        fr3_r;
  logic [EXP_Q:0]        v;
  logic [SW-1:0]         s;
  logic [F:0]            res_r;

  assign prod = d * g;
  assign idx  = p1_r[LQ-1 -: T];
  assign lo   = etab[(T+1)'(idx)];
  assign pr   = df2_r * rm2_r;
  assign v    = lo3_r - fr3_r;
  assign s    = SW'(EXP_Q - F) + SW'(n3_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= in_ctl;
      aux_r[0] <= aux_in;
      for (int k = 1; k < LAT; k++) begin
        ctl_r[k] <= ctl_r[k-1];
        aux_r[k] <= aux_r[k-1];
      end
      p1_r  <= PW'(prod >> GAM_FRAC);
      n2_r  <= p1_r[PW-1:LQ];
      lo2_r <= lo;
      df2_r <= lo - etab[(T+1)'(idx) + (T+1)'(1)];
      rm2_r <= p1_r[RW-1:0];
      n3_r  <= n2_r;
      lo3_r <= lo2_r;
      fr3_r <= (EXP_Q+1)'(pr >> RW);
      // shifts past the top bit give zero
      res_r <= (F+1)'(v >> s);
    end
  end

  assign out_vld = vld_r[LAT-1];
  assign out_ctl = ctl_r[LAT-1];
  assign aux_out = aux_r[LAT-1];
  assign res     = res_r;

endmodule

@@ hw/rtl/tone_map_operator.sv @@
// Tone map operator top level: configuration registers, sample
// classification, and the divider, log2 and power pipelines.
// Depends on tmo_pkg, tmo_if, tmo_div, tmo_log2 and tmo_exp2.
//
// Usage
//   in_if  : one linear luminance sample (Q16.16) per transaction.
//   out_if : one mapped value (Q1.OUT_FRAC_BITS) and a status per sample,
//            in input order. Status 1: luminance above the maximum luminance
//            register; status 2: the registers hold an invalid setting.
//            Value is 0 then.
//   cfg_if : register writes, always ready; write only while the block is
//            empty (no samples in flight).
// Throughput: one sample per clock, sustained, in every mode, while out_if accepts results.
// Path from input to output transaction: the 32-stage scaling divider,
//   the 4-stage log2 and power units and the OUT_FRAC_BITS+1 stage output
//   divider.
// Reset: synchronous, active low; empties the pipeline and loads the
//   register defaults (clamp mode, max and clamp level 1.0, gamma 1.0,
//   alpha 1.0).
// Stall: the whole pipeline holds while a result waits on out_if;
//   in_if.ready drops in the same cycle, nothing is lost or repeated.
module tone_map_operator import tmo_pkg::*; #(
  parameter int OUT_FRAC_BITS  = OUT_FRAC_BITS_DEF,
  parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tmo_in_if.sink    in_if,
  tmo_out_if.source out_if,
  tmo_cfg_if.sink   cfg_if
);

  localparam int F   = OUT_FRAC_BITS;
  localparam int NW2 = LUM_W + F;      // output divider numerator
  localparam int QW2 = F + 1;          // quotient: one integer bit and F fraction bits
  localparam int AW  = NW2 + LUM_W;    // numerator and divisor carried past power unit
  localparam logic [F:0] ONE_OUT = {1'b1, {F{1'b0}}};

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [MODE_W-1:0] mode_r;
  logic [LUM_W-1:0]  max_lum_r;
  logic [LUM_W-1:0]  clamp_r;
  logic [GAM_W-1:0]  gamma_r;
  logic [LUM_W-1:0]  alpha_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_CLAMP;
      max_lum_r <= LUM_ONE;
      clamp_r   <= LUM_ONE;
      gamma_r   <= GAM_W'(1) << GAM_FRAC;
      alpha_r   <= LUM_ONE;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_MODE:    mode_r    <= cfg_if.data[MODE_W-1:0];
        REG_MAX_LUM: max_lum_r <= cfg_if.data[LUM_W-1:0];
        REG_CLAMP:   clamp_r   <= cfg_if.data[LUM_W-1:0];
        REG_GAMMA:   gamma_r   <= cfg_if.data[GAM_W-1:0];
        REG_ALPHA:   alpha_r   <= cfg_if.data[LUM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Global advance: every stage moves when the output slot is free
  // ---------------------------------------------------------------
  logic adv;
  logic out_vld_r;

  assign adv         = !out_vld_r || out_if.ready;
  assign in_if.ready = adv;

  // ---------------------------------------------------------------
  // Stage 0: classify the sample, form alpha * l for log-alpha mode
  // ---------------------------------------------------------------
  logic [LUM_W-1:0] lum;
  logic             is_gamma;
  logic             uses_clamp;
  logic             cfg_bad;
  ctl_t             ctl_nxt;
  logic             s0_vld_r;
  ctl_t             s0_ctl_r;
  logic [2*LUM_W-1:0] s0_prod_r;

  assign lum        = in_if.luminance;
  assign is_gamma   = (mode_r == MODE_GAMMA) || (mode_r == MODE_GAMMA_CLAMP);
  assign uses_clamp = (mode_r == MODE_EQ_CLAMP) || (mode_r == MODE_GAMMA_CLAMP);

  always_comb begin
    cfg_bad = (mode_r > MODE_LOG_ALPHA) || (max_lum_r == '0)
           || (uses_clamp && ((clamp_r == '0) || (clamp_r > max_lum_r)))
           || (is_gamma && (gamma_r == '0))
           || ((mode_r == MODE_LOG_ALPHA) && (alpha_r == '0));
    ctl_nxt.status     = cfg_bad ? ST_CFG : ((lum > max_lum_r) ? ST_RANGE : ST_OK);
    ctl_nxt.mode       = mode_r;
    ctl_nxt.force_one  = ((mode_r == MODE_CLAMP) && (lum >= LUM_ONE))
                      || (uses_clamp && (lum >= clamp_r));
    ctl_nxt.force_zero = is_gamma && (lum == '0);
    ctl_nxt.lum        = lum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ctl_r  <= ctl_nxt;
      s0_prod_r <= alpha_r * lum;
    end
  end

  // ---------------------------------------------------------------
  // Scaling divider: t = floor(alpha * l / max)
  // ---------------------------------------------------------------
  logic             d1_vld;
  ctl_t             d1_ctl;
  logic [LUM_W-1:0] d1_t;

  tmo_div #(
    .NW (2*LUM_W),
    .DW (LUM_W),
    .QW (LUM_W)
  ) u_div_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (s0_vld_r),
    .in_ctl  (s0_ctl_r),
    .num     (s0_prod_r),
    .den     (max_lum_r),
    .out_vld (d1_vld),
    .out_ctl (d1_ctl),
    .quo     (d1_t)
  );

  // ---------------------------------------------------------------
  // log2 operands: gamma modes take reference and sample,
  // log modes take numerator and denominator plus 1.0
  // ---------------------------------------------------------------
  logic [LUM_W:0] xa;
  logic [LUM_W:0] xb;

  always_comb begin
    xa = '0;
    xb = '0;
    case (d1_ctl.mode)
      MODE_GAMMA: begin
        xa = (LUM_W+1)'(max_lum_r);
        xb = (LUM_W+1)'(d1_ctl.lum);
      end
      MODE_GAMMA_CLAMP: begin
        xa = (LUM_W+1)'(clamp_r);
        xb = (LUM_W+1)'(d1_ctl.lum);
      end
      MODE_LOG_MAX: begin
        xa = (LUM_W+1)'(d1_ctl.lum) + (LUM_W+1)'(LUM_ONE);
        xb = (LUM_W+1)'(max_lum_r) + (LUM_W+1)'(LUM_ONE);
      end
      MODE_LOG_ALPHA: begin
        xa = (LUM_W+1)'(d1_t) + (LUM_W+1)'(LUM_ONE);
        xb = (LUM_W+1)'(alpha_r) + (LUM_W+1)'(LUM_ONE);
      end
      default: ;
    endcase
  end

  logic            lg_vld;
  ctl_t            lg_ctl;
  logic [LG_W-1:0] lga;
  logic [LG_W-1:0] lgb;

  tmo_log2 #(
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_log2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (d1_vld),
    .in_ctl  (d1_ctl),
    .xa      (xa),
    .xb      (xb),
    .out_vld (lg_vld),
    .out_ctl (lg_ctl),
    .lga     (lga),
    .lgb     (lgb)
  );

  // ---------------------------------------------------------------
  // Stage 2: log differences and the output divider operands
  // ---------------------------------------------------------------
  logic [LG_W-1:0]  numl;
  logic [LG_W-1:0]  denl;
  logic [NW2-1:0]   num_nxt;
  logic [LUM_W-1:0] den_nxt;
  ctl_t             ctl2_nxt;
  logic             s2_vld_r;
  ctl_t             s2_ctl_r;
  logic [LG_W-1:0]  s2_d_r;
  logic [NW2-1:0]   s2_num_r;
  logic [LUM_W-1:0] s2_den_r;

  assign numl = lga - LOG_OFF;
  assign denl = lgb - LOG_OFF;

  always_comb begin
    ctl2_nxt = lg_ctl;
    num_nxt  = NW2'(lg_ctl.lum) << F;
    den_nxt  = LUM_W'(1);
    case (lg_ctl.mode) inside
      MODE_CLAMP:    den_nxt = LUM_ONE;
      MODE_EQ:       den_nxt = max_lum_r;
      MODE_EQ_CLAMP: den_nxt = clamp_r;
      MODE_LOG_MAX, MODE_LOG_ALPHA: begin
        num_nxt = NW2'(numl) << F;
        den_nxt = LUM_W'(denl);
        // zero denominator saturates to one
        if (denl == '0) ctl2_nxt.force_one = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= lg_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctl_r <= ctl2_nxt;
      s2_d_r   <= lga - lgb;
      s2_num_r <= num_nxt;
      s2_den_r <= den_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Power unit: 2^(-g * (log2 ref - log2 l))
  // ---------------------------------------------------------------
  logic            ex_vld;
  ctl_t            ex_ctl;
  logic [F:0]      ex_res;
  logic [AW-1:0]   ex_aux;

  tmo_exp2 #(
    .LOG_TABLE_BITS (LOG_TABLE_BITS),
    .OUT_FRAC_BITS  (OUT_FRAC_BITS),
    .AW             (AW)
  ) u_exp2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (s2_vld_r),
    .in_ctl  (s2_ctl_r),
    .d       (s2_d_r),
    .g       (gamma_r),
    .aux_in  ({s2_num_r, s2_den_r}),
    .out_vld (ex_vld),
    .out_ctl (ex_ctl),
    .res     (ex_res),
    .aux_out (ex_aux)
  );

  // Gamma results pass through the output divider over a divisor of one
  logic [NW2-1:0]   dv_num;
  logic [LUM_W-1:0] dv_den;

  always_comb begin
    if ((ex_ctl.mode == MODE_GAMMA) || (ex_ctl.mode == MODE_GAMMA_CLAMP)) begin
      dv_num = NW2'(ex_res);
      dv_den = LUM_W'(1);
    end else begin
      dv_num = ex_aux[AW-1:LUM_W];
      dv_den = ex_aux[LUM_W-1:0];
    end
  end

  logic           q_vld;
  ctl_t           q_ctl;
  logic [QW2-1:0] q;

  tmo_div #(
    .NW (NW2),
    .DW (LUM_W),
    .QW (QW2)
  ) u_div_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (ex_vld),
    .in_ctl  (ex_ctl),
    .num     (dv_num),
    .den     (dv_den),
    .out_vld (q_vld),
    .out_ctl (q_ctl),
    .quo     (q)
  );

  // ---------------------------------------------------------------
  // Output register: status first, then forced values, then saturate
  // ---------------------------------------------------------------
  logic [F:0] val_nxt;
  logic [F:0] mapped_r;
  logic [1:0] status_r;

  always_comb begin
    if (q_ctl.status != ST_OK) begin
      val_nxt = '0;
    end else if (q_ctl.force_one) begin
      val_nxt = ONE_OUT;
    end else if (q_ctl.force_zero) begin
      val_nxt = '0;
    end else begin
      val_nxt = (q > ONE_OUT) ? ONE_OUT : q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mapped_r <= val_nxt;
      status_r <= q_ctl.status;
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.mapped_value = mapped_r;
  assign out_if.status       = status_r;

endmodule

@@ hw/rtl/tmo_checker.sv @@
// Tone map operator port checker and its bind to the top level.
// Depends on tmo_pkg and tone_map_operator.
module tmo_checker import tmo_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [OUT_FRAC_BITS:0] mapped_value,
  input logic [1:0]             status
);

  localparam logic [OUT_FRAC_BITS:0] ONE_OUT = {1'b1, {OUT_FRAC_BITS{1'b0}}};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(mapped_value) && $stable(status))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_OK) |-> (mapped_value == '0))
    else $error("error status with nonzero value");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (mapped_value <= ONE_OUT))
    else $error("mapped value above one");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output slot");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind tone_map_operator tmo_checker #(
  .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_tmo_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .mapped_value (out_if.mapped_value),
  .status       (out_if.status)
);
